### src/ctps_pkg.sv
// Shared types and constants for the chime tone-pattern sequencer.
`timescale 1ns / 1ps

package ctps_pkg;

    localparam int unsigned CFG_WIDTH   = 16;
    localparam int unsigned FREQ_WIDTH  = 16;
    localparam int unsigned CIDX_WIDTH  = 3;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 24;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        PAT_OFF    = 3'd0,
        PAT_SINGLE = 3'd1,
        PAT_CHIME  = 3'd2,
        PAT_BEEP   = 3'd3,
        PAT_CONT   = 3'd4
    } pattern_t;

    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_HIGH  = 2'd1,
        SEL_LOW   = 2'd2,
        SEL_ALARM = 2'd3
    } tone_sel_t;

    typedef enum logic [CIDX_WIDTH-1:0] {
        REG_SINGLE_TONE_TICKS = 3'd0,
        REG_CHIME_TONE_TICKS  = 3'd1,
        REG_CHIME_GAP_TICKS   = 3'd2,
        REG_BEEP_PHASE_TICKS  = 3'd3,
        REG_HIGH_FREQ_HZ      = 3'd4,
        REG_LOW_FREQ_HZ       = 3'd5,
        REG_ALARM_FREQ_HZ     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] single_tone_ticks;
        logic [CFG_WIDTH-1:0] chime_tone_ticks;
        logic [CFG_WIDTH-1:0] chime_gap_ticks;
        logic [CFG_WIDTH-1:0] beep_phase_ticks;
        logic [CFG_WIDTH-1:0] high_freq_hz;
        logic [CFG_WIDTH-1:0] low_freq_hz;
        logic [CFG_WIDTH-1:0] alarm_freq_hz;
    } cfg_regs_t;

    typedef struct packed {
        pattern_t   mode;
        logic [1:0] step;
        tone_sel_t  tone_sel;
    } seq_ctl_t;

    localparam cfg_regs_t CFG_RESET = '{
        single_tone_ticks: 16'd50,
        chime_tone_ticks:  16'd25,
        chime_gap_ticks:   16'd10,
        beep_phase_ticks:  16'd20,
        high_freq_hz:      16'd1000,
        low_freq_hz:       16'd750,
        alarm_freq_hz:     16'd2000
    };

    localparam seq_ctl_t CTL_SILENT = '{
        mode:     PAT_OFF,
        step:     2'd0,
        tone_sel: SEL_NONE
    };

endpackage

### src/ctps_step.sv
// Next-state and tone-frequency logic for one sequencer request.
`timescale 1ns / 1ps

module ctps_step
    import ctps_pkg::*;
#(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  logic [1:0]            cmd,
    input  logic [2:0]            pattern,
    input  seq_ctl_t              ctl_cur,
    input  logic [TICK_WIDTH-1:0] count_cur,
    input  cfg_regs_t             cfg,
    output seq_ctl_t              ctl_next,
    output logic [TICK_WIDTH-1:0] count_next,
    output logic [FREQ_WIDTH-1:0] tone_freq
);

    function automatic logic [TICK_WIDTH-1:0] load_count(input logic [CFG_WIDTH-1:0] v);
        logic [TICK_WIDTH+CFG_WIDTH-1:0] ext;
        ext = {{TICK_WIDTH{1'b0}}, v};
        return ext[TICK_WIDTH-1:0];
    endfunction

    logic [TICK_WIDTH-1:0] count_dec;
    logic                  expire;

    assign count_dec = count_cur - TICK_WIDTH'(1);
    assign expire    = (count_cur == '0) || (count_dec == '0);

    always_comb begin
        ctl_next   = ctl_cur;
        count_next = count_cur;
        case (cmd)
            CMD_TICK: begin
                if (ctl_cur.mode != PAT_OFF) begin
                    if (count_cur != '0) begin
                        count_next = count_dec;
                    end
                    if (expire) begin
                        case (ctl_cur.mode)
                            PAT_CHIME: begin
                                if (ctl_cur.step == 2'd1) begin
                                    ctl_next.tone_sel = SEL_NONE;
                                    ctl_next.step     = 2'd2;
                                    count_next        = load_count(cfg.chime_gap_ticks);
                                end else if (ctl_cur.step == 2'd2) begin
                                    ctl_next.tone_sel = SEL_LOW;
                                    ctl_next.step     = 2'd3;
                                    count_next        = load_count(cfg.chime_tone_ticks);
                                end else begin
                                    ctl_next   = CTL_SILENT;
                                    count_next = '0;
                                end
                            end
                            PAT_BEEP: begin
                                count_next = load_count(cfg.beep_phase_ticks);
                                if (ctl_cur.step == 2'd1) begin
                                    ctl_next.tone_sel = SEL_NONE;
                                    ctl_next.step     = 2'd0;
                                end else begin
                                    ctl_next.tone_sel = SEL_ALARM;
                                    ctl_next.step     = 2'd1;
                                end
                            end
                            PAT_CONT: begin
                            end
                            default: begin
                                ctl_next   = CTL_SILENT;
                                count_next = '0;
                            end
                        endcase
                    end
                end
            end
            CMD_PLAY: begin
                case (pattern)
                    PAT_SINGLE: begin
                        ctl_next   = '{mode: PAT_SINGLE, step: 2'd0, tone_sel: SEL_HIGH};
                        count_next = load_count(cfg.single_tone_ticks);
                    end
                    PAT_CHIME: begin
                        ctl_next   = '{mode: PAT_CHIME, step: 2'd1, tone_sel: SEL_HIGH};
                        count_next = load_count(cfg.chime_tone_ticks);
                    end
                    PAT_BEEP: begin
                        ctl_next   = '{mode: PAT_BEEP, step: 2'd1, tone_sel: SEL_ALARM};
                        count_next = load_count(cfg.beep_phase_ticks);
                    end
                    PAT_CONT: begin
                        ctl_next   = '{mode: PAT_CONT, step: 2'd0, tone_sel: SEL_ALARM};
                        count_next = '0;
                    end
                    default: begin
                        ctl_next   = CTL_SILENT;
                        count_next = '0;
                    end
                endcase
            end
            CMD_STOP: begin
                ctl_next   = CTL_SILENT;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (ctl_next.tone_sel)
            SEL_HIGH:  tone_freq = cfg.high_freq_hz;
            SEL_LOW:   tone_freq = cfg.low_freq_hz;
            SEL_ALARM: tone_freq = cfg.alarm_freq_hz;
            default:   tone_freq = '0;
        endcase
    end

endmodule

### src/chime_tone_pattern_sequencer.sv
// A result is registered and appears on the m_ side in the cycle after its request is accepted.
// Throughput: one request per cycle; s_tready drops only while a result waits unread.
// The next state is formed from the pattern registers and the tick counter in one pass.
// Reset (aresetn low, synchronous): pattern off, counter cleared, registers to defaults.
// Configuration writes are taken every cycle (cfg_ready is always high).
`timescale 1ns / 1ps

module chime_tone_pattern_sequencer
    import ctps_pkg::*;
#(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // cmd[1:0], pattern[4:2], zero[7:5]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // tone_on[0], tone_freq[16:1],
                                             // active_pattern[19:17], pattern_step[21:20],
                                             // zero[23:22]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data
);

    cfg_regs_t             cfg_reg;
    seq_ctl_t              ctl_reg;
    seq_ctl_t              ctl_next;
    logic [TICK_WIDTH-1:0] count_reg;
    logic [TICK_WIDTH-1:0] count_next;
    logic [FREQ_WIDTH-1:0] freq_next;
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic                  s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SINGLE_TONE_TICKS: cfg_reg.single_tone_ticks <= cfg_data;
                REG_CHIME_TONE_TICKS:  cfg_reg.chime_tone_ticks  <= cfg_data;
                REG_CHIME_GAP_TICKS:   cfg_reg.chime_gap_ticks   <= cfg_data;
                REG_BEEP_PHASE_TICKS:  cfg_reg.beep_phase_ticks  <= cfg_data;
                REG_HIGH_FREQ_HZ:      cfg_reg.high_freq_hz      <= cfg_data;
                REG_LOW_FREQ_HZ:       cfg_reg.low_freq_hz       <= cfg_data;
                REG_ALARM_FREQ_HZ:     cfg_reg.alarm_freq_hz     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ctps_step #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_step (
        .cmd        (s_tdata[1:0]),
        .pattern    (s_tdata[4:2]),
        .ctl_cur    (ctl_reg),
        .count_cur  (count_reg),
        .cfg        (cfg_reg),
        .ctl_next   (ctl_next),
        .count_next (count_next),
        .tone_freq  (freq_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg     <= CTL_SILENT;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                ctl_reg     <= ctl_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {2'b00, ctl_next.step, ctl_next.mode, freq_next,
                           ctl_next.tone_sel != SEL_NONE};
        end
    end

endmodule
